// ===== sv/dqvr_pkg.sv =====
// Package for the deque with removal by value.
// Holds request and status codes, data widths and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package dqvr_pkg;

	localparam int DATA_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// request codes
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	// what every cell does on a given cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_REMOVE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp_en;
	} cell_ctrl_t;

endpackage

// ===== sv/dqvr_cell.sv =====
// One storage cell of the deque chain: holds one entry and its match flag.
// Depends on dqvr_pkg.
`timescale 1ns / 1ps

module dqvr_cell import dqvr_pkg::*; #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [CW-1:0]     cnt,
	input  logic [DATA_W-1:0] in_value,
	input  logic [DATA_W-1:0] op_value,
	input  logic [DATA_W-1:0] head,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic              seen_in,
	output logic              seen_out,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] tail_tap
);

	logic [DATA_W-1:0] data_q;
	logic              hit_q;
	logic              occ;
	logic              at_tail;
	logic              at_last;
	logic [DATA_W-1:0] data_d;

	// position of this cell against the fill count
	assign occ     = CW'(IDX) < cnt;
	assign at_tail = CW'(IDX) == cnt;
	assign at_last = CW'(IDX + 1) == cnt;

	// first match marker runs front to back along the chain
	assign seen_out = seen_in | (hit_q & occ);

	assign data     = data_q;
	assign tail_tap = at_last ? data_q : '0;

	// next entry value
	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			OP_PUSH_FRONT: data_d = left;
			OP_PUSH_BACK: begin
				if (at_tail) data_d = op_value;
			end
			OP_POP_FRONT: data_d = right;
			OP_REMOVE: begin
				if (seen_out) data_d = right;
			end
			OP_ROTATE: data_d = at_last ? head : right;
			default: data_d = data_q;
		endcase
	end

	// entry and compare flag; payload only, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (ctrl.cmp_en) hit_q <= (data_q == in_value);
	end

endmodule

// ===== sv/deque_with_value_removal_unit.sv =====
// Top level of the deque with removal by value: request sequencer,
// output register and the row of dqvr_cell storage cells.
// Depends on dqvr_pkg and dqvr_cell.
//
//  channel | signals                          | beat
//  --------+----------------------------------+------------------------------
//  in      | in_valid in_ready func value     | one request
//  out     | out_valid out_ready status item  | one result; count, last too
//          | count last                       |
//
// Push, pop and remove run as the accept cycle, where every cell compares its entry
// against value, then an update of the whole chain.
// Dump runs the accept and the exec state, then the chain rotates one place per beat out.
// Reset clears the fill count and the control state; entries are left as they are.
// The update, and each dump beat, waits while the output register holds a result not yet taken.
`timescale 1ns / 1ps

module deque_with_value_removal_unit import dqvr_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic signed [DATA_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STAT_W-1:0]  status,
	output logic signed [DATA_W-1:0] item,
	output logic [COUNT_W-1:0] count,
	output logic               last
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [FUNC_W-1:0]  func_q;
	logic [DATA_W-1:0]  value_q;

	logic               out_valid_q, out_valid_d;
	logic [STAT_W-1:0]  status_q, status_d;
	logic [DATA_W-1:0]  item_q, item_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               last_q, last_d;

	logic               accept;
	logic               ofree;
	logic               full;
	logic               empty;
	logic               found;
	cell_ctrl_t         ctrl;

	logic [DATA_W-1:0]  data_w [CAPACITY];
	logic [DATA_W-1:0]  tail_w [CAPACITY];
	logic               seen_w [CAPACITY+1];
	logic [DATA_W-1:0]  tail_data;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign ofree     = !out_valid_q || out_ready;
	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign found     = seen_w[CAPACITY];

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign count     = count_q;
	assign last      = last_q;

	// row of cells
	assign seen_w[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = value_q;
		end else begin : g_mid
			assign left_w = data_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_w = data_w[i];
		end else begin : g_inner
			assign right_w = data_w[i+1];
		end
		dqvr_cell #(.CW(CW), .IDX(i)) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.cnt      (cnt_q),
			.in_value (value),
			.op_value (value_q),
			.head     (data_w[0]),
			.left     (left_w),
			.right    (right_w),
			.seen_in  (seen_w[i]),
			.seen_out (seen_w[i+1]),
			.data     (data_w[i]),
			.tail_tap (tail_w[i])
		);
	end

	// back entry: only the cell at the back drives its tap
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < CAPACITY; i++) tail_data = tail_data | tail_w[i];
	end

	// sequencer and result selection
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		out_valid_d = out_valid_q && !out_ready;
		status_d    = status_q;
		item_d      = item_q;
		count_d     = count_q;
		last_d      = last_q;
		ctrl.op     = OP_HOLD;
		ctrl.cmp_en = accept;
		case (state_q)
			S_IDLE: begin
				if (accept && func <= FN_DUMP) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (ofree) begin
					state_d     = S_IDLE;
					out_valid_d = 1'b1;
					last_d      = 1'b1;
					status_d    = STAT_OK;
					item_d      = value_q;
					case (func_q)
						FN_PUSH_FRONT, FN_PUSH_BACK: begin
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								ctrl.op = (func_q == FN_PUSH_FRONT) ? OP_PUSH_FRONT
									: OP_PUSH_BACK;
								cnt_d = cnt_q + 1'b1;
							end
						end
						FN_POP_FRONT, FN_POP_BACK: begin
							if (empty) begin
								status_d = STAT_EMPTY;
								item_d   = '0;
							end else begin
								if (func_q == FN_POP_FRONT) begin
									ctrl.op = OP_POP_FRONT;
									item_d  = data_w[0];
								end else begin
									item_d = tail_data;
								end
								cnt_d = cnt_q - 1'b1;
							end
						end
						FN_REMOVE: begin
							if (empty) begin
								status_d = STAT_EMPTY;
							end else if (found) begin
								ctrl.op = OP_REMOVE;
								cnt_d   = cnt_q - 1'b1;
							end else begin
								status_d = STAT_NOTFOUND;
							end
						end
						default: begin
							// dump
							if (empty) begin
								status_d = STAT_EMPTY;
								item_d   = '0;
							end else begin
								out_valid_d = out_valid_q && !out_ready;
								state_d     = S_DUMP;
								idx_d       = '0;
							end
						end
					endcase
					count_d = COUNT_W'(cnt_d);
				end
			end
			S_DUMP: begin
				if (ofree) begin
					ctrl.op     = OP_ROTATE;
					out_valid_d = 1'b1;
					status_d    = STAT_OK;
					item_d      = data_w[0];
					count_d     = COUNT_W'(cnt_q);
					last_d      = (idx_q == cnt_q - 1'b1);
					idx_d       = idx_q + 1'b1;
					if (idx_q == cnt_q - 1'b1) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			value_q <= value;
		end
		status_q <= status_d;
		item_q   <= item_d;
		count_q  <= count_d;
		last_q   <= last_d;
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> cnt_q != '0)
		else $error("dump running on an empty sequence");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> idx_q < cnt_q)
		else $error("dump position past the back");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> state_q == S_DUMP)
		else $error("non-final beat with no dump in progress");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == STAT_EMPTY |-> count_q == '0)
		else $error("empty status with non-zero count");

endmodule
